### sv/dsl_pkg.sv
`default_nettype none

package dsl_pkg;

  // Coordinate width of the endpoints.
  localparam int unsigned COORD_BITS = 8;
  // Width of the decision variable and its increments.
  localparam int unsigned DEC_BITS = 12;
  // Loop pass counter width: up to 63 passes of four pixels.
  localparam int unsigned LOOP_BITS = 6;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  // One input beat.
  typedef struct packed {
    logic [7:0]  x_start;
    logic [7:0]  y_start;
    logic [7:0]  x_end;
    logic [7:0]  y_end;
    logic [31:0] colour;
  } line_in_t;

  // One result beat: a group of up to four pixels.
  typedef struct packed {
    logic [7:0]  px0;
    logic [7:0]  py0;
    logic [7:0]  px1;
    logic [7:0]  py1;
    logic [7:0]  px2;
    logic [7:0]  py2;
    logic [7:0]  px3;
    logic [7:0]  py3;
    logic [2:0]  pixel_count;
    logic [31:0] pixel_colour;
    logic        last_group;
  } group_out_t;

  // A plotted pixel in screen coordinates.
  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
  } pixel_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic tail;
    logic extra;
  } dsl_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic zero_len;
    logic loops_done;
    logic tail_full;
  } dsl_stat_t;

  // Map a major/minor point back to x/y.
  function automatic pixel_t mk_px(input logic swp, input coord_t major, input coord_t minor);
    pixel_t p;
    p.x = 8'(swp ? minor : major);
    p.y = 8'(swp ? major : minor);
    return p;
  endfunction

endpackage

`default_nettype wire

### sv/dsl_ctrl.sv
`default_nettype none

module dsl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire dsl_pkg::dsl_stat_t stat,
  output dsl_pkg::dsl_cmd_t       cmd,
  output logic                    busy
);
  import dsl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_LOOP  = 4'b0100,
    ST_EXTRA = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = stat.zero_len ? ST_IDLE : ST_LOOP;
      end
      ST_LOOP: begin
        if (stat.loops_done) begin
          cmd.tail = 1'b1;
          state_nxt = stat.tail_full ? ST_EXTRA : ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_EXTRA: begin
        cmd.extra = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register not one-hot");
  a_start_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_SETUP))
    else $error("accepted line did not enter setup");
  a_step_loops: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !stat.loops_done)
    else $error("loop pass issued with no passes left");
  a_extra_after_tail: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.extra |-> $past(cmd.tail))
    else $error("extra group without a preceding tail");
`endif

endmodule

`default_nettype wire

### sv/dsl_dp.sv
`default_nettype none

module dsl_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dsl_pkg::line_in_t  in_data,
  input  wire dsl_pkg::dsl_cmd_t  cmd,
  output dsl_pkg::dsl_stat_t      stat,
  output logic                    out_valid,
  output dsl_pkg::group_out_t     out_data
);
  import dsl_pkg::*;

  localparam coord_t CMASK = coord_t'((1 << COORD_BITS) - 1);

  line_in_t in_r;
  coord_t   fmaj_r, fmin_r, bmaj_r, bmin_r;
  dec_t     dec_r, pb_r, ia_r, ib_r;
  logic [LOOP_BITS-1:0] loops_r;
  logic [1:0] tail_r;
  logic     neg_r, swp_r, steep_r;
  pixel_t   carry0_r, carry1_r, extra_r;
  logic     out_valid_r;
  group_out_t out_r, out_nxt;

  // Setup: deltas, axis swap and initial decision terms.
  coord_t xs, ys, xe, ye, dx0, dy0, dx, dy, ms, me, ns, ne, dm1;
  logic   sxn, syn, swp, steep;
  dec_t   dxe, dye, ib0, pb0, ia0, d0;
  always_comb begin
    xs = in_r.x_start & CMASK;
    ys = in_r.y_start & CMASK;
    xe = in_r.x_end & CMASK;
    ye = in_r.y_end & CMASK;
    sxn = xe < xs;
    syn = ye < ys;
    dx0 = sxn ? xs - xe : xe - xs;
    dy0 = syn ? ys - ye : ye - ys;
    swp = dy0 > dx0;
    dx = swp ? dy0 : dx0;
    dy = swp ? dx0 : dy0;
    ms = swp ? ys : xs;
    me = swp ? ye : xe;
    ns = swp ? xs : ys;
    ne = swp ? xe : ye;
    dxe = dec_t'({1'b0, dx});
    dye = dec_t'({1'b0, dy});
    ib0 = (dye <<< 2) - (dxe <<< 1);
    steep = !ib0[DEC_BITS-1];
    pb0 = steep ? (dye - dxe) <<< 1 : dye <<< 1;
    ia0 = pb0 <<< 1;
    d0 = steep ? ia0 + dxe : ia0 - dxe;
    dm1 = dx - coord_t'(1);
  end

  // One double-step pass: minor steps for the two forward and two backward pixels.
  logic   c1, lt, gt;
  logic [1:0] s1, s2, sb1;
  coord_t f1n, f2n, b1n, b2n, f1m, f2m, b1m, b2m;
  pixel_t pf1, pf2, pb1, pb2;
  always_comb begin
    c1 = steep_r ? (dec_r > 0) : (dec_r < 0);
    lt = dec_r < pb_r;
    gt = dec_r > pb_r;
    if (c1) begin
      s1 = steep_r ? 2'd1 : 2'd0;
      s2 = steep_r ? 2'd2 : 2'd0;
    end else if (lt) begin
      s1 = 2'd0;
      s2 = 2'd1;
    end else begin
      s1 = 2'd1;
      s2 = 2'd1;
    end
    // The tail's backward pixel holds its minor on a steep line at the bound.
    sb1 = s1;
    if (cmd.tail && !c1 && !lt && steep_r && !gt) sb1 = 2'd0;
    f1m = fmaj_r + coord_t'(1);
    f2m = fmaj_r + coord_t'(2);
    b1m = bmaj_r - coord_t'(1);
    b2m = bmaj_r - coord_t'(2);
    f1n = neg_r ? fmin_r - coord_t'(s1) : fmin_r + coord_t'(s1);
    f2n = neg_r ? fmin_r - coord_t'(s2) : fmin_r + coord_t'(s2);
    b1n = neg_r ? bmin_r + coord_t'(sb1) : bmin_r - coord_t'(sb1);
    b2n = neg_r ? bmin_r + coord_t'(s2) : bmin_r - coord_t'(s2);
    pf1 = mk_px(swp_r, f1m, f1n);
    pf2 = mk_px(swp_r, f2m, f2n);
    pb1 = mk_px(swp_r, b1m, b1n);
    pb2 = mk_px(swp_r, b2m, b2n);
  end

  assign stat.zero_len   = (dx == '0);
  assign stat.loops_done = (loops_r == '0);
  assign stat.tail_full  = (tail_r == 2'd3);

  // Input capture and line state.
  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
    if (cmd.setup) begin
      swp_r   <= swp;
      neg_r   <= sxn != syn;
      steep_r <= steep;
      pb_r    <= pb0;
      ia_r    <= ia0;
      ib_r    <= ib0;
      dec_r   <= d0;
      loops_r <= dm1[COORD_BITS-1:2];
      tail_r  <= dm1[1:0];
      if (ms > me) begin
        fmaj_r <= me; fmin_r <= ne; bmaj_r <= ms; bmin_r <= ns;
        carry0_r <= mk_px(swp, me, ne);
        carry1_r <= mk_px(swp, ms, ns);
      end else begin
        fmaj_r <= ms; fmin_r <= ns; bmaj_r <= me; bmin_r <= ne;
        carry0_r <= mk_px(swp, ms, ns);
        carry1_r <= mk_px(swp, me, ne);
      end
    end
    if (cmd.step) begin
      fmaj_r  <= f2m;
      fmin_r  <= f2n;
      bmaj_r  <= b2m;
      bmin_r  <= b2n;
      dec_r   <= c1 ? dec_r + ia_r : dec_r + ib_r;
      loops_r <= loops_r - LOOP_BITS'(1);
      carry0_r <= pb1;
      carry1_r <= pb2;
    end
    if (cmd.tail) extra_r <= pb1;
  end

  // Next result group: unused slots stay zero.
  always_comb begin
    out_nxt = '0;
    out_nxt.pixel_colour = in_r.colour;
    if (cmd.setup) begin
      out_nxt.px0 = 8'(xs);
      out_nxt.py0 = 8'(ys);
      out_nxt.pixel_count = 3'd1;
      out_nxt.last_group = 1'b1;
    end else if (cmd.step) begin
      {out_nxt.px0, out_nxt.py0} = carry0_r;
      {out_nxt.px1, out_nxt.py1} = carry1_r;
      {out_nxt.px2, out_nxt.py2} = pf1;
      {out_nxt.px3, out_nxt.py3} = pf2;
      out_nxt.pixel_count = 3'd4;
    end else if (cmd.tail) begin
      {out_nxt.px0, out_nxt.py0} = carry0_r;
      {out_nxt.px1, out_nxt.py1} = carry1_r;
      if (tail_r != 2'd0) {out_nxt.px2, out_nxt.py2} = pf1;
      if (tail_r[1]) {out_nxt.px3, out_nxt.py3} = pf2;
      out_nxt.pixel_count = stat.tail_full ? 3'd4 : 3'd2 + 3'(tail_r);
      out_nxt.last_group = !stat.tail_full;
    end else begin
      {out_nxt.px0, out_nxt.py0} = extra_r;
      out_nxt.pixel_count = 3'd1;
      out_nxt.last_group = 1'b1;
    end
  end

  // Result group register.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.setup && stat.zero_len) || cmd.step || cmd.tail || cmd.extra;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pixel_count != 3'd0 && out_data.pixel_count <= 3'd4))
    else $error("group pixel count out of range");
  a_step_full: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.step) |-> (out_data.pixel_count == 3'd4 && !out_data.last_group))
    else $error("loop group not full or marked last");
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.setup, cmd.step, cmd.tail, cmd.extra}))
    else $error("more than one datapath command");
`endif

endmodule

`default_nettype wire

### sv/double_step_line_rasterizer_core.sv
`default_nettype none
// Symmetric double-step line rasterizer.
// Input channel: a line beat (two clipped endpoints and a colour) is taken
// on a clock edge where start is high and busy is low. busy stays high until
// the last pixel group of the line has been issued.
// Result channel: each group of up to four pixels appears on out_data for
// exactly one cycle with out_valid high; pixel_count tells how many slots
// hold pixels and unused slots read zero. last_group marks the final group.
// The receiver cannot stall; every group is consumed when shown.
// Sequence: the accepting cycle, the setup state, then one loop pass of the
// sequencer per four-pixel group, a tail group, and one more group when the
// tail leaves five pixels. A zero-length line gives a single group from the
// setup state. Each group is registered before it is shown. The next line
// may be accepted in the cycle where busy falls, while the last group is
// shown.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid; any line in progress is abandoned.
module double_step_line_rasterizer_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire dsl_pkg::line_in_t   in_data,
  output logic                     out_valid,
  output dsl_pkg::group_out_t      out_data
);
  import dsl_pkg::*;

  dsl_cmd_t  cmd;
  dsl_stat_t stat;

  // Sequencer.
  dsl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Stepping and packing datapath.
  dsl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import dsl_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  line_in_t in_data = '0;
  logic out_valid;
  group_out_t out_data;

  double_step_line_rasterizer_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #6 clk = ~clk;

  group_out_t want_groups[$];
  int errors = 0;
  int lines_sent = 0;
  int groups_seen = 0;

  // Group builder state for the line predictor.
  pixel_t stage[4];
  int stage_fill;
  logic swp;
  logic [31:0] line_colour;

  task automatic report(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic flush_stage(input bit last);
    group_out_t g;
    if (stage_fill == 0) return;
    g = '0;
    g.px0 = stage[0].x; g.py0 = stage[0].y;
    if (stage_fill > 1) begin g.px1 = stage[1].x; g.py1 = stage[1].y; end
    if (stage_fill > 2) begin g.px2 = stage[2].x; g.py2 = stage[2].y; end
    if (stage_fill > 3) begin g.px3 = stage[3].x; g.py3 = stage[3].y; end
    g.pixel_count = 3'(stage_fill);
    g.pixel_colour = line_colour;
    g.last_group = last;
    want_groups.push_back(g);
    stage_fill = 0;
  endtask

  task automatic put_pixel(input int major, input int minor);
    pixel_t p;
    p.x = 8'(swp ? minor : major);
    p.y = 8'(swp ? major : minor);
    if (stage_fill == 4) flush_stage(1'b0);
    stage[stage_fill] = p;
    stage_fill++;
  endtask

  // Predict every pixel group of one line.
  task automatic predict_line(input line_in_t li);
    int xs, ys, xe, ye, dx, dy, t, st, i;
    int fa, fi, ba, bi, dec, bound, inc_a, inc_b, loops, tail;
    bit sxn, syn, steep;
    xs = li.x_start; ys = li.y_start; xe = li.x_end; ye = li.y_end;
    line_colour = li.colour;
    stage_fill = 0;
    swp = 1'b0;
    sxn = xe < xs; syn = ye < ys;
    dx = sxn ? xs - xe : xe - xs;
    dy = syn ? ys - ye : ye - ys;
    if (dx == 0 && dy == 0) begin
      put_pixel(xs, ys);
      flush_stage(1'b1);
      return;
    end
    st = (sxn != syn) ? -1 : 1;
    if (dy > dx) begin
      t = xs; xs = ys; ys = t;
      t = xe; xe = ye; ye = t;
      t = dx; dx = dy; dy = t;
      swp = 1'b1;
    end
    if (xs > xe) begin
      fa = xe; fi = ye; ba = xs; bi = ys;
    end else begin
      fa = xs; fi = ys; ba = xe; bi = ye;
    end
    loops = (dx - 1) / 4;
    tail = (dx - 1) % 4;
    put_pixel(fa, fi);
    put_pixel(ba, bi);
    inc_b = 4 * dy - 2 * dx;
    steep = inc_b >= 0;
    bound = steep ? 2 * (dy - dx) : 2 * dy;
    inc_a = 2 * bound;
    dec = steep ? inc_a + dx : inc_a - dx;
    for (i = 0; i < loops; i++) begin
      fa++; ba--;
      if (!steep ? (dec < 0) : (dec > 0)) begin
        if (!steep) begin
          put_pixel(fa, fi); fa++; put_pixel(fa, fi);
          put_pixel(ba, bi); ba--; put_pixel(ba, bi);
        end else begin
          fi += st; put_pixel(fa, fi); fa++; fi += st; put_pixel(fa, fi);
          bi -= st; put_pixel(ba, bi); ba--; bi -= st; put_pixel(ba, bi);
        end
        dec += inc_a;
      end else begin
        if (dec < bound) begin
          put_pixel(fa, fi); fa++; fi += st; put_pixel(fa, fi);
          put_pixel(ba, bi); ba--; bi -= st; put_pixel(ba, bi);
        end else begin
          fi += st; put_pixel(fa, fi); fa++; put_pixel(fa, fi);
          bi -= st; put_pixel(ba, bi); ba--; put_pixel(ba, bi);
        end
        dec += inc_b;
      end
    end
    if (tail != 0) begin
      if (!steep ? (dec < 0) : (dec > 0)) begin
        if (!steep) begin
          fa++; put_pixel(fa, fi);
          if (tail > 1) begin fa++; put_pixel(fa, fi); end
          if (tail > 2) begin ba--; put_pixel(ba, bi); end
        end else begin
          fa++; fi += st; put_pixel(fa, fi);
          if (tail > 1) begin fa++; fi += st; put_pixel(fa, fi); end
          if (tail > 2) begin ba--; bi -= st; put_pixel(ba, bi); end
        end
      end else if (dec < bound) begin
        fa++; put_pixel(fa, fi);
        if (tail > 1) begin fa++; fi += st; put_pixel(fa, fi); end
        if (tail > 2) begin ba--; put_pixel(ba, bi); end
      end else begin
        fa++; fi += st; put_pixel(fa, fi);
        if (tail > 1) begin fa++; put_pixel(fa, fi); end
        if (tail > 2) begin
          ba--;
          if (!steep || dec > bound) bi -= st;
          put_pixel(ba, bi);
        end
      end
    end
    flush_stage(1'b1);
  endtask

  // Compare each group beat against the oldest expected group.
  always @(posedge clk) begin
    group_out_t w;
    if (rst_n && out_valid) begin
      groups_seen++;
      if (want_groups.size() == 0) begin
        report($sformatf("unexpected group %p", out_data));
      end else begin
        w = want_groups.pop_front();
        if (out_data.px0 !== w.px0 || out_data.py0 !== w.py0)
          report($sformatf("pixel 0 got %0d,%0d want %0d,%0d",
                           out_data.px0, out_data.py0, w.px0, w.py0));
        if (out_data.px1 !== w.px1 || out_data.py1 !== w.py1)
          report($sformatf("pixel 1 got %0d,%0d want %0d,%0d",
                           out_data.px1, out_data.py1, w.px1, w.py1));
        if (out_data.px2 !== w.px2 || out_data.py2 !== w.py2)
          report($sformatf("pixel 2 got %0d,%0d want %0d,%0d",
                           out_data.px2, out_data.py2, w.px2, w.py2));
        if (out_data.px3 !== w.px3 || out_data.py3 !== w.py3)
          report($sformatf("pixel 3 got %0d,%0d want %0d,%0d",
                           out_data.px3, out_data.py3, w.px3, w.py3));
        if (out_data.pixel_count !== w.pixel_count)
          report($sformatf("count got %0d want %0d", out_data.pixel_count, w.pixel_count));
        if (out_data.pixel_colour !== w.pixel_colour)
          report($sformatf("colour got %h want %h", out_data.pixel_colour, w.pixel_colour));
        if (out_data.last_group !== w.last_group)
          report($sformatf("last got %b want %b", out_data.last_group, w.last_group));
      end
    end
  end

  // Offer one line beat from the falling edge and hold it until accepted.
  task automatic send_line(input line_in_t li);
    @(negedge clk);
    start <= 1'b1;
    in_data <= li;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_line(li);
    lines_sent++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic maybe_idle(input bit quiet);
    if (!quiet && $urandom_range(99) < 9)
      repeat ($urandom_range(1, 8)) @(negedge clk);
  endtask

  function automatic line_in_t mk_line(input int xs, input int ys, input int xe,
                                       input int ye, input logic [31:0] c);
    line_in_t li;
    li.x_start = 8'(xs); li.y_start = 8'(ys);
    li.x_end = 8'(xe); li.y_end = 8'(ye); li.colour = c;
    return li;
  endfunction

  line_in_t directed[$];
  group_out_t one_px;

  initial begin
    line_in_t li;
    int n, base, len;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A zero-length line is one pixel in one final group.
    one_px = '0;
    one_px.px0 = 8'd255; one_px.py0 = 8'd0;
    one_px.pixel_count = 3'd1; one_px.pixel_colour = 32'hFFFFFFFF;
    one_px.last_group = 1'b1;
    li = mk_line(255, 0, 255, 0, 32'hFFFFFFFF);
    send_line(li);
    want_groups.pop_back();
    want_groups.push_back(one_px);

    // Directed table: extremes, octants and every tail length.
    directed.push_back(mk_line(0, 0, 0, 0, 32'h0));
    directed.push_back(mk_line(0, 0, 255, 255, 32'hA5A5A5A5));
    directed.push_back(mk_line(255, 255, 0, 0, 32'h5A5A5A5A));
    directed.push_back(mk_line(0, 255, 255, 0, 32'h12345678));
    directed.push_back(mk_line(0, 0, 255, 0, 32'hFFFFFFFF));
    directed.push_back(mk_line(0, 0, 0, 255, 32'h1));
    directed.push_back(mk_line(255, 0, 0, 1, 32'h80000000));
    directed.push_back(mk_line(10, 10, 11, 10, 32'h2));
    directed.push_back(mk_line(10, 10, 12, 11, 32'h3));
    directed.push_back(mk_line(10, 10, 13, 11, 32'h4));
    directed.push_back(mk_line(10, 10, 14, 12, 32'h5));
    directed.push_back(mk_line(10, 10, 15, 13, 32'h6));
    directed.push_back(mk_line(10, 10, 18, 13, 32'h7));
    directed.push_back(mk_line(50, 50, 43, 55, 32'h8));
    directed.push_back(mk_line(50, 50, 55, 41, 32'h9));
    directed.push_back(mk_line(20, 40, 30, 45, 32'hA));
    directed.push_back(mk_line(20, 40, 24, 43, 32'hB));
    directed.push_back(mk_line(100, 0, 0, 37, 32'hC));
    foreach (directed[i]) begin
      send_line(directed[i]);
      maybe_idle(1'b0);
    end

    // Let every group drain before the random lines start.
    while (want_groups.size() != 0) @(posedge clk);

    // Random lines: mostly short, some full range, some quiet stretches.
    for (n = 0; n < 140; n++) begin
      if (n % 40 == 0) begin
        li = mk_line($urandom_range(255), $urandom_range(255),
                     $urandom_range(255), $urandom_range(255), $urandom);
      end else begin
        base = $urandom_range(255);
        len = $urandom_range(0, 20);
        li.x_start = 8'($urandom_range(255));
        li.y_start = 8'($urandom_range(255));
        li.x_end = ($urandom_range(1)) ? li.x_start + 8'(len) : li.x_start - 8'(len);
        li.y_end = ($urandom_range(1)) ? li.y_start + 8'($urandom_range(0, len))
                                       : li.y_start - 8'($urandom_range(0, len));
        if ($urandom_range(1)) begin
          base = li.x_end; li.x_end = li.y_end; li.y_end = 8'(base);
          base = li.x_start; li.x_start = li.y_start; li.y_start = 8'(base);
        end
        li.colour = $urandom;
      end
      send_line(li);
      maybe_idle(n >= 60 && n < 100);
      if (n == 120)
        while (want_groups.size() != 0) @(posedge clk);
    end

    while (want_groups.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Covered %0d lines in all octants with all tail lengths, %0d groups checked.",
             lines_sent, groups_seen);
    if (errors == 0 && want_groups.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

### double_step_line_rasterizer_core.f
sv/dsl_pkg.sv
sv/dsl_ctrl.sv
sv/dsl_dp.sv
sv/double_step_line_rasterizer_core.sv
sim/tb.sv
